@@ src/spcr_pkg.sv @@
// Shared types and constants for the shape pair collide/resolve core.
// No dependencies; imported by every module of the block.
package spcr_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;

  typedef enum logic {
    KIND_CIRCLE = 1'b0,
    KIND_RECT   = 1'b1
  } shape_kind_e;

  typedef enum logic [1:0] {
    MOVED_NONE   = 2'd0,
    MOVED_FIRST  = 2'd1,
    MOVED_SECOND = 2'd2
  } moved_e;

  // Per-word control that travels beside the coordinates
  typedef struct packed {
    logic   hit;
    moved_e moved;
    logic   zero_dist;
    logic   push;    // circle pair push still to be added from the divider lanes
    logic   neg_x;   // sign of a_x - b_x
    logic   neg_y;   // sign of a_y - b_y
  } pair_flags_t;

endpackage

@@ src/spcr_front.sv @@
// Front pipeline (five stages): differences, squares, rectangle tests and the
// circle/rectangle push-out. Depends on spcr_pkg.
module spcr_front import spcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic                           kind_a_i,
  input  logic                           kind_b_i,
  input  logic signed [COORD_BITS-1:0]   a_x_i,
  input  logic signed [COORD_BITS-1:0]   a_y_i,
  input  logic signed [COORD_BITS-1:0]   b_x_i,
  input  logic signed [COORD_BITS-1:0]   b_y_i,
  input  logic        [COORD_BITS-2:0]   a_extent_x_i,
  input  logic        [COORD_BITS-2:0]   a_extent_y_i,
  input  logic        [COORD_BITS-2:0]   b_extent_x_i,
  input  logic        [COORD_BITS-2:0]   b_extent_y_i,
  output logic                           valid_o,
  output pair_flags_t                    flags_o,
  output logic signed [COORD_BITS-1:0]   new_x_o,
  output logic signed [COORD_BITS-1:0]   new_y_o,
  output logic signed [COORD_BITS-1:0]   cx_o,
  output logic signed [COORD_BITS-1:0]   cy_o,
  output logic        [COORD_BITS-1:0]   mag_x_o,
  output logic        [COORD_BITS-1:0]   mag_y_o,
  output logic        [2*COORD_BITS-1:0] diff_o,
  output logic        [2*COORD_BITS-1:0] dist_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned W2 = 2 * COORD_BITS;
  localparam logic [C-1:0] MinV = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0] MaxV = {1'b0, {(C-1){1'b1}}};

  // ---------------- stage A: differences and extent sums
  logic a_v_q;
  logic a_ka_q, a_kb_q;
  logic signed [C:0] a_dx_q, a_dy_q, a_dx_d, a_dy_d;
  logic [C:0] a_wr_q, a_hr_q, a_wr_d, a_hr_d;
  logic [C-1:0] a_rsum_q, a_hsum_q, a_rsum_d, a_hsum_d;
  logic signed [C-1:0] a_cx_q, a_cy_q, a_cx_d, a_cy_d;
  logic a_first;
  logic [C-2:0] a_r, a_w, a_h;

  always_comb begin
    a_first  = (kind_a_i == KIND_CIRCLE);
    a_r      = a_first ? a_extent_x_i : b_extent_x_i;
    a_w      = a_first ? b_extent_x_i : a_extent_x_i;
    a_h      = a_first ? b_extent_y_i : a_extent_y_i;
    a_dx_d   = {a_x_i[C-1], a_x_i} - {b_x_i[C-1], b_x_i};
    a_dy_d   = {a_y_i[C-1], a_y_i} - {b_y_i[C-1], b_y_i};
    a_wr_d   = {2'b00, a_w} + {1'b0, a_r, 1'b0};
    a_hr_d   = {2'b00, a_h} + {1'b0, a_r, 1'b0};
    a_rsum_d = {1'b0, a_extent_x_i} + {1'b0, b_extent_x_i};
    a_hsum_d = {1'b0, a_extent_y_i} + {1'b0, b_extent_y_i};
    a_cx_d   = a_first ? a_x_i : b_x_i;
    a_cy_d   = a_first ? a_y_i : b_y_i;
  end

  // ---------------- stage B: magnitudes and signs
  logic b_v_q;
  logic b_ka_q, b_kb_q;
  logic [C-1:0] b_mdx_q, b_mdy_q, b_mdx_d, b_mdy_d;
  logic b_negx_q, b_negy_q, b_nzx_q, b_nzy_q;
  logic [C:0] b_wr_q, b_hr_q;
  logic [C-1:0] b_rsum_q, b_hsum_q;
  logic signed [C-1:0] b_cx_q, b_cy_q;
  logic [C:0] b_ndx, b_ndy;

  always_comb begin
    b_ndx   = -a_dx_q;
    b_ndy   = -a_dy_q;
    b_mdx_d = a_dx_q[C] ? b_ndx[C-1:0] : a_dx_q[C-1:0];
    b_mdy_d = a_dy_q[C] ? b_ndy[C-1:0] : a_dy_q[C-1:0];
  end

  // ---------------- stage C: squares, rectangle test, penetrations
  logic c_v_q;
  logic c_ka_q, c_kb_q;
  logic [W2-1:0] c_sqx_q, c_sqy_q, c_rad_q, c_sqx_d, c_sqy_d, c_rad_d;
  logic c_rrhit_q, c_rrhit_d;
  logic signed [C+1:0] c_px2_q, c_py2_q, c_px2_d, c_py2_d;
  logic [C-1:0] c_mdx_q, c_mdy_q;
  logic c_negx_q, c_negy_q;
  logic c_crnegx_q, c_crnzx_q, c_crnegy_q, c_crnzy_q;
  logic c_crnegx_d, c_crnegy_d;
  logic signed [C-1:0] c_cx_q, c_cy_q;
  logic c_first;

  always_comb begin
    c_first     = (b_ka_q == KIND_CIRCLE);
    c_sqx_d     = {{C{1'b0}}, b_mdx_q} * {{C{1'b0}}, b_mdx_q};
    c_sqy_d     = {{C{1'b0}}, b_mdy_q} * {{C{1'b0}}, b_mdy_q};
    c_rad_d     = {{C{1'b0}}, b_rsum_q} * {{C{1'b0}}, b_rsum_q};
    c_rrhit_d   = ({b_mdx_q, 1'b0} <= {1'b0, b_rsum_q}) &&
                  ({b_mdy_q, 1'b0} <= {1'b0, b_hsum_q});
    c_px2_d     = {1'b0, b_wr_q} - {1'b0, b_mdx_q, 1'b0};
    c_py2_d     = {1'b0, b_hr_q} - {1'b0, b_mdy_q, 1'b0};
    // circle minus rectangle flips the sign when the circle is second
    c_crnegx_d  = c_first ? b_negx_q : (b_nzx_q & ~b_negx_q);
    c_crnegy_d  = c_first ? b_negy_q : (b_nzy_q & ~b_negy_q);
  end

  // ---------------- stage D: distance sum, axis choice
  logic d_v_q;
  logic d_ka_q, d_kb_q;
  logic [W2-1:0] d_rad_q;
  logic [W2:0] d_dist_q, d_dist_d;
  logic d_rrhit_q, d_crhit_q, d_usex_q, d_crneg_q, d_crnz_q;
  logic d_crhit_d, d_usex_d;
  logic [C:0] d_half_q, d_half_d;
  logic [C-1:0] d_mdx_q, d_mdy_q;
  logic d_negx_q, d_negy_q;
  logic signed [C-1:0] d_cx_q, d_cy_q;
  logic signed [C+1:0] d_sel;

  always_comb begin
    d_dist_d  = {1'b0, c_sqx_q} + {1'b0, c_sqy_q};
    d_crhit_d = !c_px2_q[C+1] && (|c_px2_q) && !c_py2_q[C+1] && (|c_py2_q);
    d_usex_d  = (c_px2_q < c_py2_q);
    d_sel     = d_usex_d ? c_px2_q : c_py2_q;
    d_half_d  = d_sel[C+1:1];
  end

  // ---------------- stage E: circle pair test, circle/rectangle result
  logic e_v_q;
  pair_flags_t e_flags_q, e_flags_d;
  logic signed [C-1:0] e_nx_q, e_ny_q, e_nx_d, e_ny_d;
  logic signed [C-1:0] e_cx_q, e_cy_q;
  logic [C-1:0] e_mdx_q, e_mdy_q;
  logic [W2-1:0] e_diff_q, e_dist_q, e_diff_d;
  logic e_cc, e_rr, e_chit, e_zero;
  logic signed [C-1:0] e_base, e_sat;
  logic signed [C+1:0] e_half_ext, e_delta, e_sum;

  always_comb begin
    e_cc       = (d_ka_q == KIND_CIRCLE) && (d_kb_q == KIND_CIRCLE);
    e_rr       = (d_ka_q == KIND_RECT) && (d_kb_q == KIND_RECT);
    e_chit     = ({1'b0, d_rad_q} >= d_dist_q);
    e_zero     = ~|d_dist_q;
    e_diff_d   = d_rad_q - d_dist_q[W2-1:0];
    // push the circle out along the shallower axis
    e_base     = d_usex_q ? d_cx_q : d_cy_q;
    e_half_ext = {1'b0, d_half_q};
    e_delta    = !d_crnz_q ? '0 : (d_crneg_q ? -e_half_ext : e_half_ext);
    e_sum      = {{2{e_base[C-1]}}, e_base} + e_delta;
    if (e_sum[C+1:C-1] == '0 || e_sum[C+1:C-1] == '1) begin
      e_sat = e_sum[C-1:0];
    end else begin
      e_sat = e_sum[C+1] ? MinV : MaxV;
    end

    e_flags_d       = '0;
    e_flags_d.moved = MOVED_NONE;
    e_flags_d.neg_x = d_negx_q;
    e_flags_d.neg_y = d_negy_q;
    e_nx_d          = '0;
    e_ny_d          = '0;
    if (e_cc) begin
      e_flags_d.hit       = e_chit;
      e_flags_d.zero_dist = e_chit & e_zero;
      e_flags_d.push      = e_chit & ~e_zero;
      e_flags_d.moved     = (e_chit & ~e_zero) ? MOVED_FIRST : MOVED_NONE;
    end else if (e_rr) begin
      e_flags_d.hit = d_rrhit_q;
    end else if (d_crhit_q) begin
      e_flags_d.hit   = 1'b1;
      e_flags_d.moved = (d_ka_q == KIND_CIRCLE) ? MOVED_FIRST : MOVED_SECOND;
      e_nx_d          = d_usex_q ? e_sat : d_cx_q;
      e_ny_d          = d_usex_q ? d_cy_q : e_sat;
    end
  end

  // Valid bits advance with the shared enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  // Payload advances without reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ka_q     <= kind_a_i;
      a_kb_q     <= kind_b_i;
      a_dx_q     <= a_dx_d;
      a_dy_q     <= a_dy_d;
      a_wr_q     <= a_wr_d;
      a_hr_q     <= a_hr_d;
      a_rsum_q   <= a_rsum_d;
      a_hsum_q   <= a_hsum_d;
      a_cx_q     <= a_cx_d;
      a_cy_q     <= a_cy_d;

      b_ka_q     <= a_ka_q;
      b_kb_q     <= a_kb_q;
      b_mdx_q    <= b_mdx_d;
      b_mdy_q    <= b_mdy_d;
      b_negx_q   <= a_dx_q[C];
      b_negy_q   <= a_dy_q[C];
      b_nzx_q    <= |a_dx_q;
      b_nzy_q    <= |a_dy_q;
      b_wr_q     <= a_wr_q;
      b_hr_q     <= a_hr_q;
      b_rsum_q   <= a_rsum_q;
      b_hsum_q   <= a_hsum_q;
      b_cx_q     <= a_cx_q;
      b_cy_q     <= a_cy_q;

      c_ka_q     <= b_ka_q;
      c_kb_q     <= b_kb_q;
      c_sqx_q    <= c_sqx_d;
      c_sqy_q    <= c_sqy_d;
      c_rad_q    <= c_rad_d;
      c_rrhit_q  <= c_rrhit_d;
      c_px2_q    <= c_px2_d;
      c_py2_q    <= c_py2_d;
      c_mdx_q    <= b_mdx_q;
      c_mdy_q    <= b_mdy_q;
      c_negx_q   <= b_negx_q;
      c_negy_q   <= b_negy_q;
      c_crnegx_q <= c_crnegx_d;
      c_crnzx_q  <= b_nzx_q;
      c_crnegy_q <= c_crnegy_d;
      c_crnzy_q  <= b_nzy_q;
      c_cx_q     <= b_cx_q;
      c_cy_q     <= b_cy_q;

      d_ka_q     <= c_ka_q;
      d_kb_q     <= c_kb_q;
      d_rad_q    <= c_rad_q;
      d_dist_q   <= d_dist_d;
      d_rrhit_q  <= c_rrhit_q;
      d_crhit_q  <= d_crhit_d;
      d_usex_q   <= d_usex_d;
      d_half_q   <= d_half_d;
      d_crneg_q  <= d_usex_d ? c_crnegx_q : c_crnegy_q;
      d_crnz_q   <= d_usex_d ? c_crnzx_q : c_crnzy_q;
      d_mdx_q    <= c_mdx_q;
      d_mdy_q    <= c_mdy_q;
      d_negx_q   <= c_negx_q;
      d_negy_q   <= c_negy_q;
      d_cx_q     <= c_cx_q;
      d_cy_q     <= c_cy_q;

      e_flags_q  <= e_flags_d;
      e_nx_q     <= e_nx_d;
      e_ny_q     <= e_ny_d;
      e_cx_q     <= d_cx_q;
      e_cy_q     <= d_cy_q;
      e_mdx_q    <= d_mdx_q;
      e_mdy_q    <= d_mdy_q;
      e_diff_q   <= e_diff_d;
      e_dist_q   <= d_dist_q[W2-1:0];
    end
  end

  assign valid_o = e_v_q;
  assign flags_o = e_flags_q;
  assign new_x_o = e_nx_q;
  assign new_y_o = e_ny_q;
  assign cx_o    = e_cx_q;
  assign cy_o    = e_cy_q;
  assign mag_x_o = e_mdx_q;
  assign mag_y_o = e_mdy_q;
  assign diff_o  = e_diff_q;
  assign dist_o  = e_dist_q;

endmodule

@@ src/spcr_push_div.sv @@
// One push lane: numerator product over two stages, then a pipelined restoring
// divider (one quotient bit per stage) and a clamp stage. Depends on spcr_pkg.
module spcr_push_div import spcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [COORD_BITS-1:0]     mag_i,
  input  logic [2*COORD_BITS-1:0]   diff_i,
  input  logic [2*COORD_BITS-1:0]   dist_i,
  output logic [COORD_BITS+1:0]     quot_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned W2   = 2 * COORD_BITS;
  localparam int unsigned QW   = COORD_BITS + 2;
  localparam int unsigned NW   = 3 * COORD_BITS;
  localparam int unsigned HW   = NW - QW;
  localparam int unsigned PadW = W2 - HW;
  localparam logic [QW-1:0] Lim = {1'b1, {(QW-1){1'b0}}};

  // Partial products, then the full numerator
  logic [W2-1:0] lo_q, hi_q, f_dist_q, g_dist_q;
  logic [NW-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q     <= {{C{1'b0}}, mag_i} * {{C{1'b0}}, diff_i[C-1:0]};
      hi_q     <= {{C{1'b0}}, mag_i} * {{C{1'b0}}, diff_i[W2-1:C]};
      f_dist_q <= dist_i;
      num_q    <= {hi_q, {C{1'b0}}} + {{C{1'b0}}, lo_q};
      g_dist_q <= f_dist_q;
    end
  end

  // Divider stage registers; index 0 is the overflow check
  logic [W2-1:0] rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [W2-1:0] dv_q  [QW+1];
  logic          ovf_q [QW+1];
  logic [QW-1:0] quot_q;

  logic [W2-1:0] init_top;
  logic          init_ovf;

  always_comb begin
    init_top = {{PadW{1'b0}}, num_q[NW-1:QW]};
    init_ovf = (init_top >= g_dist_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= init_ovf ? '0 : init_top;
      quo_q[0] <= '0;
      low_q[0] <= num_q[QW-1:0];
      dv_q[0]  <= g_dist_q;
      ovf_q[0] <= init_ovf;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [W2+1:0] trial, sub;
    logic [QW-1:0] quo_d;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
      trial = {1'b0, rem_q[k-1], low_q[k-1][QW-k]};
      sub   = trial - {2'b00, dv_q[k-1]};
      quo_d = quo_q[k-1];
      quo_d[QW-k] = ~sub[W2+1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= sub[W2+1] ? trial[W2-1:0] : sub[W2-1:0];
        quo_q[k] <= quo_d;
        low_q[k] <= low_q[k-1];
        dv_q[k]  <= dv_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Clamp the push magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= (ovf_q[QW] || (quo_q[QW] > Lim)) ? Lim : quo_q[QW];
    end
  end

  assign quot_o = quot_q;

endmodule

@@ src/spcr_outbuf.sv @@
// Two-word output buffer that decouples the pipeline from the result consumer.
// Depends on spcr_pkg for COORD_BITS_DEF, used in the default data width.
module spcr_outbuf import spcr_pkg::*; #(
  parameter int unsigned DATA_W = 2 * COORD_BITS_DEF + 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/shape_pair_collide_resolve_core.sv @@
// One pair accepted per cycle while the output is drained.
// Depth comes from the circle push division, one quotient bit per stage.
// A two-word output buffer holds results; the pipe stalls only when it is full.
// Reset (rst_ni low, async) clears all valid bits and the output buffer.
module shape_pair_collide_resolve_core import spcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_a_i,
  input  logic                         kind_b_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic        [COORD_BITS-2:0] a_extent_x_i,
  input  logic        [COORD_BITS-2:0] a_extent_y_i,
  input  logic        [COORD_BITS-2:0] b_extent_x_i,
  input  logic        [COORD_BITS-2:0] b_extent_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [1:0]                   moved_object_o,
  output logic signed [COORD_BITS-1:0] new_x_o,
  output logic signed [COORD_BITS-1:0] new_y_o,
  output logic                         zero_distance_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned W2    = 2 * COORD_BITS;
  localparam int unsigned QW    = COORD_BITS + 2;
  localparam int unsigned Lat   = QW + 4;
  localparam int unsigned DataW = 2 * COORD_BITS + 4;
  localparam logic [C-1:0] MinV = {1'b1, {(C-1){1'b0}}};
  localparam logic [C-1:0] MaxV = {1'b0, {(C-1){1'b1}}};

  logic en;
  logic buf_full, buf_push;

  logic                fr_valid;
  pair_flags_t         fr_flags;
  logic signed [C-1:0] fr_nx, fr_ny, fr_cx, fr_cy;
  logic [C-1:0]        fr_mag_x, fr_mag_y;
  logic [W2-1:0]       fr_diff, fr_dist;
  logic [QW-1:0]       quot_x, quot_y;

  // Sideband that rides beside the push lanes
  logic                sb_v_q     [Lat];
  pair_flags_t         sb_flags_q [Lat];
  logic signed [C-1:0] sb_nx_q    [Lat];
  logic signed [C-1:0] sb_ny_q    [Lat];
  logic signed [C-1:0] sb_cx_q    [Lat];
  logic signed [C-1:0] sb_cy_q    [Lat];

  // Advance the whole pipe unless the last word cannot leave
  assign en         = ~(sb_v_q[Lat-1] & buf_full);
  assign in_ready_o = en;
  assign buf_push   = en & sb_v_q[Lat-1];

  spcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .kind_a_i     (kind_a_i),
    .kind_b_i     (kind_b_i),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .a_extent_x_i (a_extent_x_i),
    .a_extent_y_i (a_extent_y_i),
    .b_extent_x_i (b_extent_x_i),
    .b_extent_y_i (b_extent_y_i),
    .valid_o      (fr_valid),
    .flags_o      (fr_flags),
    .new_x_o      (fr_nx),
    .new_y_o      (fr_ny),
    .cx_o         (fr_cx),
    .cy_o         (fr_cy),
    .mag_x_o      (fr_mag_x),
    .mag_y_o      (fr_mag_y),
    .diff_o       (fr_diff),
    .dist_o       (fr_dist)
  );

  spcr_push_div #(.COORD_BITS(COORD_BITS)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (fr_mag_x),
    .diff_i (fr_diff),
    .dist_i (fr_dist),
    .quot_o (quot_x)
  );

  spcr_push_div #(.COORD_BITS(COORD_BITS)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (fr_mag_y),
    .diff_i (fr_diff),
    .dist_i (fr_dist),
    .quot_o (quot_y)
  );

  // Delay the sideband by the lane latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        sb_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      sb_v_q[0] <= fr_valid;
      for (int i = 1; i < Lat; i++) begin
        sb_v_q[i] <= sb_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_flags_q[0] <= fr_flags;
      sb_nx_q[0]    <= fr_nx;
      sb_ny_q[0]    <= fr_ny;
      sb_cx_q[0]    <= fr_cx;
      sb_cy_q[0]    <= fr_cy;
      for (int i = 1; i < Lat; i++) begin
        sb_flags_q[i] <= sb_flags_q[i-1];
        sb_nx_q[i]    <= sb_nx_q[i-1];
        sb_ny_q[i]    <= sb_ny_q[i-1];
        sb_cx_q[i]    <= sb_cx_q[i-1];
        sb_cy_q[i]    <= sb_cy_q[i-1];
      end
    end
  end

  // Add a signed push to a centre and saturate to the coordinate range
  function automatic logic [C-1:0] sat_push(input logic [C-1:0] base,
                                            input logic [QW-1:0] amount,
                                            input logic neg);
    logic [C+2:0] ext;
    logic [C+2:0] sum;
    logic [C-1:0] res;
    ext = {1'b0, amount};
    sum = {{3{base[C-1]}}, base} + (neg ? -ext : ext);
    if (sum[C+2:C-1] == '0 || sum[C+2:C-1] == '1) begin
      res = sum[C-1:0];
    end else begin
      res = sum[C+2] ? MinV : MaxV;
    end
    return res;
  endfunction

  pair_flags_t         last_flags;
  logic signed [C-1:0] fin_x, fin_y;
  logic [DataW-1:0]    buf_wdata, buf_rdata;

  // Finish the circle pair push
  always_comb begin
    last_flags = sb_flags_q[Lat-1];
    fin_x      = sb_nx_q[Lat-1];
    fin_y      = sb_ny_q[Lat-1];
    if (last_flags.push) begin
      fin_x = sat_push(sb_cx_q[Lat-1], quot_x, last_flags.neg_x);
      fin_y = sat_push(sb_cy_q[Lat-1], quot_y, last_flags.neg_y);
    end
    buf_wdata = {last_flags.hit, last_flags.moved, fin_x, fin_y, last_flags.zero_dist};
  end

  spcr_outbuf #(.DATA_W(DataW)) u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (buf_push),
    .data_i  (buf_wdata),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (buf_rdata)
  );

  assign hit_o           = buf_rdata[DataW-1];
  assign moved_object_o  = buf_rdata[DataW-2:DataW-3];
  assign new_x_o         = buf_rdata[W2:C+1];
  assign new_y_o         = buf_rdata[C:1];
  assign zero_distance_o = buf_rdata[0];

  // The buffer never takes a word while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(buf_push && buf_full))
    else $error("output buffer written while full");

  // A pending circle push always belongs to a hit that moves the first object
  a_push_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sb_v_q[Lat-1] && last_flags.push) |->
      (last_flags.hit && last_flags.moved == MOVED_FIRST && !last_flags.zero_dist))
    else $error("circle push without a first-object hit");

  // Nothing moved means zeroed coordinates
  a_unmoved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && moved_object_o == MOVED_NONE) |-> (new_x_o == '0 && new_y_o == '0))
    else $error("coordinates reported for an unmoved pair");

  // Coincident centres are a hit with no push
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_distance_o) |-> (hit_o && moved_object_o == MOVED_NONE))
    else $error("zero distance flagged on a non-hit or moved pair");

endmodule
